// ----- hdl/anpe_pkg.sv -----
// package for the arm next pc evaluator: status codes, operation codes, shared functions
// no dependencies
`timescale 1ns / 1ps
package anpe_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_EVAL   = 2'd1,
    OP_SUPPLY = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_UNALIGNED  = 3'd2,
    ST_UNPRED     = 3'd3,
    ST_UNSUP      = 3'd4,
    ST_LOADREQ    = 3'd5,
    ST_NOLOAD     = 3'd6
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] target;
    logic        thumb;
    logic [31:0] laddr;
  } result_t;

  localparam int unsigned NumRegs = 15;

  function automatic result_t mk_result(status_e st, logic [31:0] tgt, logic th,
                                        logic [31:0] la);
    result_t r;
    r.status = st;
    r.target = tgt;
    r.thumb  = th;
    r.laddr  = la;
    return r;
  endfunction

  function automatic result_t interwork(logic [31:0] a);
    result_t r;
    if (a[0]) r = mk_result(ST_OK, {a[31:1], 1'b0}, 1'b1, 32'd0);
    else if (a[1]) r = mk_result(ST_UNPRED, 32'd0, 1'b0, 32'd0);
    else r = mk_result(ST_OK, a, 1'b0, 32'd0);
    return r;
  endfunction

endpackage

// ----- hdl/anpe_decode.sv -----
// combinational next pc evaluation for one arm instruction
// depends on anpe_pkg; register operands come from the register file in the top level
`timescale 1ns / 1ps
module anpe_decode (
  input  logic [31:0]      ins_i,
  input  logic [31:0]      pc_i,
  input  logic [31:0]      cpsr_i,
  input  logic [31:0]      regs_i [15],
  output anpe_pkg::result_t res_o
);
  import anpe_pkg::*;

  logic [31:0] pc8, pc4, rm_val, rn_val, sh_val, op2, r, off_b, ldr_off, base, addr;
  logic [31:0] start, ldm_addr;
  logic [3:0]  cond, rm, rn, op;
  logic [4:0]  amt;
  logic [4:0]  cnt;
  logic        n, z, cy, v, cok, carry;

  function automatic logic [31:0] rd(logic [3:0] i, logic [31:0] p8,
                                     logic [31:0] rf [15]);
    return (i == 4'd15) ? p8 : rf[i];
  endfunction

  always_comb begin
    pc8   = pc_i + 32'd8;
    pc4   = {pc_i[31:2] + 30'd1, 2'b00};
    cond  = ins_i[31:28];
    rm    = ins_i[3:0];
    rn    = ins_i[19:16];
    op    = ins_i[24:21];
    amt   = ins_i[11:7];
    n = cpsr_i[31]; z = cpsr_i[30]; cy = cpsr_i[29]; v = cpsr_i[28];
    carry = cy;
    case (cond)
      4'h0: cok = z;
      4'h1: cok = !z;
      4'h2: cok = cy;
      4'h3: cok = !cy;
      4'h4: cok = n;
      4'h5: cok = !n;
      4'h6: cok = v;
      4'h7: cok = !v;
      4'h8: cok = cy && !z;
      4'h9: cok = !cy || z;
      4'ha: cok = n == v;
      4'hb: cok = n != v;
      4'hc: cok = !z && (n == v);
      4'hd: cok = z || (n != v);
      4'he: cok = 1'b1;
      default: cok = 1'b0;
    endcase
    rm_val = rd(rm, pc8, regs_i);
    rn_val = rd(rn, pc8, regs_i);
    // immediate shifter
    case (ins_i[6:5])
      2'd0: sh_val = rm_val << amt;
      2'd1: sh_val = (amt == 5'd0) ? 32'd0 : rm_val >> amt;
      2'd2: sh_val = (amt == 5'd0) ? {32{rm_val[31]}} : 32'($signed(rm_val) >>> amt);
      default: sh_val = (amt == 5'd0) ? {carry, rm_val[31:1]}
                                      : ((rm_val >> amt) | (rm_val << (6'd32 - {1'b0, amt})));
    endcase
    if (ins_i[25]) op2 = {24'd0, ins_i[7:0]} >> {ins_i[11:8], 1'b0}
                       | {24'd0, ins_i[7:0]} << (6'd32 - {1'b0, ins_i[11:8], 1'b0});
    else op2 = sh_val;
    if (ins_i[11:8] == 4'd0 && ins_i[25]) op2 = {24'd0, ins_i[7:0]};
    case (op)
      4'h0: r = rn_val & op2;
      4'h1: r = rn_val ^ op2;
      4'h2: r = rn_val - op2;
      4'h3: r = op2 - rn_val;
      4'h4: r = rn_val + op2;
      4'h5: r = rn_val + op2 + {31'd0, carry};
      4'h6: r = rn_val - op2 - {31'd0, !carry};
      4'h7: r = op2 - rn_val - {31'd0, !carry};
      4'hc: r = rn_val | op2;
      4'hd: r = op2;
      4'he: r = rn_val & ~op2;
      default: r = ~op2;
    endcase
    off_b   = {{6{ins_i[23]}}, ins_i[23:0], 2'b00};
    ldr_off = ins_i[25] ? sh_val : {20'd0, ins_i[11:0]};
    base    = rn_val;
    addr    = !ins_i[24] ? base : (ins_i[23] ? base + ldr_off : base - ldr_off);
    cnt = 5'd0;
    for (int i = 0; i < 16; i++) cnt = cnt + 5'(ins_i[i]);
    if (ins_i[23]) start = base + (ins_i[24] ? 32'd4 : 32'd0);
    else start = base - {25'd0, cnt, 2'b00} + (ins_i[24] ? 32'd0 : 32'd4);
    ldm_addr = start + {25'd0, cnt - 5'd1, 2'b00};

    res_o = mk_result(ST_OK, pc4, 1'b0, 32'd0);
    if (cpsr_i[5] || cpsr_i[24]) res_o = mk_result(ST_INVALID, 32'd0, 1'b0, 32'd0);
    else if (pc_i[1:0] != 2'd0) res_o = mk_result(ST_UNALIGNED, 32'd0, 1'b0, 32'd0);
    else if (cond != 4'hf && !cok) res_o = mk_result(ST_OK, pc4, 1'b0, 32'd0);
    else if ((ins_i & 32'hfe000000) == 32'hfa000000)
      res_o = mk_result(ST_OK, (pc8 + (off_b | {30'd0, ins_i[24], 1'b0})) & ~32'd1,
                        1'b1, 32'd0);
    else if (cond == 4'hf) res_o = mk_result(ST_OK, pc4, 1'b0, 32'd0);
    else if ((ins_i & 32'h0ffffff0) == 32'h012fff20)
      res_o = mk_result(ST_UNSUP, 32'd0, 1'b0, 32'd0);
    else if ((ins_i & 32'hfff000f0) == 32'he1200070 || ins_i[27:24] == 4'hf)
      res_o = mk_result(ST_UNSUP, 32'd0, 1'b0, 32'd0);
    else if ((ins_i & 32'h0ffffff0) == 32'h012fff10 ||
             (ins_i & 32'h0ffffff0) == 32'h012fff30) begin
      if (ins_i[5] && rm == 4'd15) res_o = mk_result(ST_UNPRED, 32'd0, 1'b0, 32'd0);
      else res_o = interwork(rm_val);
    end else if (ins_i[27:25] == 3'b101)
      res_o = mk_result(ST_OK, (pc8 + off_b) & ~32'd3, 1'b0, 32'd0);
    else if ((ins_i & 32'h0e100000) == 32'h08100000 && ins_i[15]) begin
      if (ins_i[22]) res_o = mk_result(ST_UNSUP, 32'd0, 1'b0, 32'd0);
      else if (rn == 4'd15 || (ins_i[21] && ins_i[rn]))
        res_o = mk_result(ST_UNPRED, 32'd0, 1'b0, 32'd0);
      else if (ldm_addr[1:0] != 2'd0) res_o = mk_result(ST_UNALIGNED, 32'd0, 1'b0, 32'd0);
      else res_o = mk_result(ST_LOADREQ, 32'd0, 1'b0, ldm_addr);
    end else if ((ins_i & 32'h0c100000) == 32'h04100000 && ins_i[15:12] == 4'hf) begin
      if (ins_i[22] || (!ins_i[24] && ins_i[21]) ||
          (rn == 4'd15 && (!ins_i[24] || ins_i[21])) ||
          (ins_i[25] && (ins_i[4] || rm == 4'd15)))
        res_o = mk_result(ST_UNPRED, 32'd0, 1'b0, 32'd0);
      else if (addr[1:0] != 2'd0) res_o = mk_result(ST_UNALIGNED, 32'd0, 1'b0, 32'd0);
      else res_o = mk_result(ST_LOADREQ, 32'd0, 1'b0, addr);
    end else if (!((ins_i & 32'h0fb0fff0) == 32'h0120f000 ||
                   (ins_i & 32'h0fb0f000) == 32'h0320f000) &&
                 ((ins_i & 32'h0e000000) == 32'h02000000 ||
                  (ins_i & 32'h0e000010) == 32'h00000000 ||
                  (ins_i & 32'h0e000090) == 32'h00000010) &&
                 ins_i[15:12] == 4'hf) begin
      if ((!ins_i[25] && ins_i[4]) || (op[3:2] == 2'b10))
        res_o = mk_result(ST_UNPRED, 32'd0, 1'b0, 32'd0);
      else if (ins_i[20]) res_o = mk_result(ST_UNSUP, 32'd0, 1'b0, 32'd0);
      else res_o = mk_result(ST_OK, r & ~32'd3, 1'b0, 32'd0);
    end
  end

endmodule

// ----- hdl/arm_next_pc_evaluator.sv -----
// top level of the arm next pc evaluator: input register, register file, result register
// depends on anpe_pkg and anpe_decode
// path from input transfer to result valid: input register, then result register
// throughput: one item per cycle while the output is not stalled; the decode is a single combinational pass
// a full output register holds while stalled; the input register drains into it when it is free
// reset clears valid flags, the register file and the pending-load flag
`timescale 1ns / 1ps
module arm_next_pc_evaluator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], reg_index[5:2], data_word[37:6], instruction[69:38],
  // pc[101:70], cpsr[133:102], zero fill to 136
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], target_address[34:3], thumb[35], load_address[67:36], zero fill to 72
  output logic [71:0]  m_axis_tdata
);
  import anpe_pkg::*;

  logic [133:0] in_q;
  logic         in_vld_q, out_vld_q;
  result_t      out_q, res_d, dec_res;
  logic [31:0]  rf_q [NumRegs];
  logic         pend_q, pend_d;
  logic         adv, out_free;
  op_e          op;
  logic [3:0]   idx;
  logic [31:0]  data;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign op   = op_e'(in_q[1:0]);
  assign idx  = in_q[5:2];
  assign data = in_q[37:6];

  anpe_decode u_dec (
    .ins_i (in_q[69:38]),
    .pc_i  (in_q[101:70]),
    .cpsr_i(in_q[133:102]),
    .regs_i(rf_q),
    .res_o (dec_res)
  );

  always_comb begin
    pend_d = pend_q;
    unique case (op)
      OP_WRITE: res_d = mk_result(ST_OK, 32'd0, 1'b0, 32'd0);
      OP_EVAL: begin
        res_d  = dec_res;
        pend_d = dec_res.status == ST_LOADREQ;
      end
      OP_SUPPLY: begin
        if (!pend_q) res_d = mk_result(ST_NOLOAD, 32'd0, 1'b0, 32'd0);
        else begin
          res_d  = interwork(data);
          pend_d = 1'b0;
        end
      end
      default: res_d = mk_result(ST_UNSUP, 32'd0, 1'b0, 32'd0);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      for (int i = 0; i < NumRegs; i++) rf_q[i] <= 32'd0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_free) out_vld_q <= in_vld_q;
      if (adv) begin
        pend_q <= pend_d;
        if (op == OP_WRITE && idx != 4'd15) rf_q[idx] <= data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= s_axis_tdata[133:0];
    if (adv) out_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_q.laddr, out_q.thumb, out_q.target, out_q.status};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> $stable(out_q))
    else $error("result changed while stalled");
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && op == OP_SUPPLY |=> !pend_q)
    else $error("pending load not cleared");
  a_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.status == ST_LOADREQ |=> pend_q)
    else $error("load request without pending flag");

endmodule
